/* sv/qdi_pkg.sv */
// Package for the quadrature decoder with index.
// Holds item and result types, register codes and field widths; no dependencies.
`default_nettype none
package qdi_pkg;

   localparam int unsigned CountWidth   = 32;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 232;

   // Register indexes on the configuration port
   localparam logic CSR_RELOAD_DIR_HIGH = 1'b0;
   localparam logic CSR_RELOAD_DIR_LOW  = 1'b1;

   // Item kinds carried in req_tuser
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   localparam logic [CountWidth-1:0] RELOAD_DIR_HIGH_RESET = 32'd0;
   localparam logic [CountWidth-1:0] RELOAD_DIR_LOW_RESET  = 32'd4096;

   typedef struct packed {
      logic                  action;
      logic                  pin_a;
      logic                  pin_b;
      logic                  pin_index;
      logic                  pin_dir;
      logic [CountWidth-1:0] load_value;
   } item_type;

   typedef struct packed {
      logic                  illegal_transition;
      logic                  index_seen;
      logic [CountWidth-1:0] index_count;
      logic [CountWidth-1:0] edges_on_b;
      logic [CountWidth-1:0] edges_on_a;
      logic [CountWidth-1:0] edges_last_revolution;
      logic [CountWidth-1:0] edges_since_index;
      logic [CountWidth-1:0] position_at_index;
      logic [CountWidth-1:0] position;
   } result_type;

endpackage
`default_nettype wire

/* sv/qdi_in_stage.sv */
// Input register of the quadrature decoder with index.
// Holds one request beat until the core consumes it; uses qdi_pkg.
`default_nettype none
module qdi_in_stage
   import qdi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   input  wire logic     advance,
   output logic          item_valid,
   output item_type      item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   // Accept when empty or when the held beat leaves this cycle
   assign in_ready = !valid_ff || advance;
   assign take     = in_valid && in_ready;
   assign valid_in = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

/* sv/qdi_core.sv */
// Decoder state, reload registers and next-state logic.
// Updates counters once per consumed item; uses qdi_pkg.
`default_nettype none
module qdi_core
   import qdi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CountWidth-1:0] csr_wdata,
   input  wire logic                  advance,
   input  wire item_type              item,
   output result_type                 result
);

   logic [CountWidth-1:0] reload_high_val_ff;
   logic [CountWidth-1:0] reload_low_val_ff;

   logic                  prev_a_ff, prev_a_in;
   logic                  prev_b_ff, prev_b_in;
   logic                  prev_index_ff, prev_index_in;
   logic [CountWidth-1:0] position_ff, position_in;
   logic [CountWidth-1:0] index_position_ff, index_position_in;
   logic [CountWidth-1:0] edge_count_ff, edge_count_in;
   logic [CountWidth-1:0] saved_edge_count_ff, saved_edge_count_in;
   logic [CountWidth-1:0] a_total_ff, a_total_in;
   logic [CountWidth-1:0] b_total_ff, b_total_in;
   logic [CountWidth-1:0] index_total_ff, index_total_in;
   logic                  seen_ff, seen_in;
   logic                  illegal;

   logic                  a_change;
   logic                  b_change;
   logic                  count_up;
   logic [CountWidth-1:0] step_position;
   logic [CountWidth-1:0] step_edges;

   // Reload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_high_val_ff <= RELOAD_DIR_HIGH_RESET;
         reload_low_val_ff  <= RELOAD_DIR_LOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RELOAD_DIR_HIGH: reload_high_val_ff <= csr_wdata;
            CSR_RELOAD_DIR_LOW:  reload_low_val_ff  <= csr_wdata;
            default:             reload_low_val_ff  <= reload_low_val_ff;
         endcase
      end
   end

   assign a_change = item.pin_a != prev_a_ff;
   assign b_change = item.pin_b != prev_b_ff;
   // A edge counts up when A differs from B after it, B edge when they match
   assign count_up = a_change ? (item.pin_a ^ item.pin_b) : !(item.pin_a ^ item.pin_b);
   assign step_position = count_up ? position_ff + 1'b1 : position_ff - 1'b1;
   assign step_edges    = edge_count_ff + 1'b1;

   always_comb begin
      prev_a_in           = prev_a_ff;
      prev_b_in           = prev_b_ff;
      prev_index_in       = prev_index_ff;
      position_in         = position_ff;
      index_position_in   = index_position_ff;
      edge_count_in       = edge_count_ff;
      saved_edge_count_in = saved_edge_count_ff;
      a_total_in          = a_total_ff;
      b_total_in          = b_total_ff;
      index_total_in      = index_total_ff;
      seen_in             = seen_ff;
      illegal             = 1'b0;
      if (item.action == ACT_LOAD) begin
         if (position_ff != item.load_value) begin
            position_in   = item.load_value;
            edge_count_in = item.load_value;
         end
      end else begin
         priority if (a_change && b_change) begin
            illegal = 1'b1;
         end else if (a_change) begin
            position_in   = step_position;
            edge_count_in = step_edges;
            a_total_in    = a_total_ff + 1'b1;
         end else if (b_change) begin
            position_in   = step_position;
            edge_count_in = step_edges;
            b_total_in    = b_total_ff + 1'b1;
         end else begin
            illegal = 1'b0;
         end
         // Index rising edge: latch after the A/B step, then reload
         if (item.pin_index && !prev_index_ff) begin
            seen_in             = 1'b1;
            index_position_in   = position_in;
            position_in         = item.pin_dir ? reload_high_val_ff : reload_low_val_ff;
            saved_edge_count_in = edge_count_in;
            edge_count_in       = '0;
            index_total_in      = index_total_ff + 1'b1;
         end
         prev_a_in     = item.pin_a;
         prev_b_in     = item.pin_b;
         prev_index_in = item.pin_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff           <= 1'b0;
         prev_b_ff           <= 1'b0;
         prev_index_ff       <= 1'b0;
         position_ff         <= '0;
         index_position_ff   <= '0;
         edge_count_ff       <= '0;
         saved_edge_count_ff <= '0;
         a_total_ff          <= '0;
         b_total_ff          <= '0;
         index_total_ff      <= '0;
         seen_ff             <= 1'b0;
      end else if (advance) begin
         prev_a_ff           <= prev_a_in;
         prev_b_ff           <= prev_b_in;
         prev_index_ff       <= prev_index_in;
         position_ff         <= position_in;
         index_position_ff   <= index_position_in;
         edge_count_ff       <= edge_count_in;
         saved_edge_count_ff <= saved_edge_count_in;
         a_total_ff          <= a_total_in;
         b_total_ff          <= b_total_in;
         index_total_ff      <= index_total_in;
         seen_ff             <= seen_in;
      end
   end

   always_comb begin
      result.position              = position_in;
      result.position_at_index     = index_position_in;
      result.edges_since_index     = edge_count_in;
      result.edges_last_revolution = saved_edge_count_in;
      result.edges_on_a            = a_total_in;
      result.edges_on_b            = b_total_in;
      result.index_count           = index_total_in;
      result.index_seen            = seen_in;
      result.illegal_transition    = illegal;
   end

endmodule
`default_nettype wire

/* sv/qdi_out_stage.sv */
// Result register of the quadrature decoder with index.
// Holds one response beat until the receiver takes it; uses qdi_pkg.
`default_nettype none
module qdi_out_stage
   import qdi_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   output logic            advance,
   input  wire result_type result_in,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // Advance when an item waits and the register is free or draining
   assign advance  = item_valid && (!valid_ff || out_ready);
   assign valid_in = advance || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;

endmodule
`default_nettype wire

/* sv/quadrature_decoder_with_index.sv */
// Top level of the x4 quadrature decoder with index handling.
// Instantiates qdi_in_stage, qdi_core and qdi_out_stage; uses qdi_pkg.
//
// Usage:
//   req_*  carries one beat per pin sample or position load. req_tuser is
//          the item kind (sample or load); req_tdata holds the pin levels
//          and the load value.
//   rsp_*  returns exactly one beat per request beat with the decoder
//          state after that item: position, latched index values, edge
//          counters and the illegal-transition flag for this item.
//   csr_*  writes the two index reload registers; write only while idle.
// Path: an accepted beat passes the input register, then the result
// register; the A/B/index update is one pass of combinational logic
// between them.
// Throughput: one beat per cycle while rsp_tready stays high, set by
// the state update loop in qdi_core.
// Stall: while rsp_tready is low the result register holds its beat, the
// input register fills, and then req_tready drops; nothing is lost.
// Reset (synchronous, active high) empties both registers, clears all
// counters and pin history, and loads reload_dir_low with 4096 and
// reload_dir_high with 0.
`default_nettype none
module quadrature_decoder_with_index
   import qdi_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // req_tdata from bit 0: pin_a, pin_b, pin_index, pin_dir,
   //   load_value[31:0], zero pad
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   // req_tuser: action (0 pin sample, 1 load)
   input  wire logic                    req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // rsp_tdata from bit 0: position, position_at_index, edges_since_index,
   //   edges_last_revolution, edges_on_a, edges_on_b, index_count
   //   (32 bits each), index_seen, illegal_transition, zero pad
   output logic [RspDataWidth-1:0]      rsp_tdata,
   input  wire logic                    csr_we,
   input  wire logic                    csr_index,
   input  wire logic [CountWidth-1:0]   csr_wdata
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type core_result;
   result_type rsp_result;

   // Unpack the request beat
   always_comb begin
      req_item.action     = req_tuser;
      req_item.pin_a      = req_tdata[0];
      req_item.pin_b      = req_tdata[1];
      req_item.pin_index  = req_tdata[2];
      req_item.pin_dir    = req_tdata[3];
      req_item.load_value = req_tdata[4 +: CountWidth];
   end

   qdi_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Commit the state update only on the cycle the item moves forward
   qdi_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item),
      .result    (core_result)
   );

   qdi_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .advance    (advance),
      .result_in  (core_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .result     (rsp_result)
   );

   // Pack the response beat, position in the lowest bits
   assign rsp_tdata = {{(RspDataWidth - $bits(result_type)){1'b0}}, rsp_result};

endmodule
`default_nettype wire

/* sv/qdi_checker.sv */
// Port-level checks for quadrature_decoder_with_index, bound to the top.
// Uses qdi_pkg for widths.
`default_nettype none
module qdi_checker
   import qdi_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_tvalid,
   input wire logic                    rsp_tready,
   input wire logic [RspDataWidth-1:0] rsp_tdata
);

   logic                  seen;
   logic                  illegal;
   logic [CountWidth-1:0] a_total;
   logic [CountWidth-1:0] b_total;
   logic [CountWidth-1:0] index_total;
   logic [CountWidth-1:0] index_position;

   assign index_position = rsp_tdata[32 +: CountWidth];
   assign a_total        = rsp_tdata[128 +: CountWidth];
   assign b_total        = rsp_tdata[160 +: CountWidth];
   assign index_total    = rsp_tdata[192 +: CountWidth];
   assign seen           = rsp_tdata[224];
   assign illegal        = rsp_tdata[225];

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // No index yet: index counters still at reset
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !seen |-> index_total == '0 && index_position == '0)
      else $error("index values set before any index pulse");

   // Illegal A/B change leaves both edge totals as in the previous beat
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_tvalid && rsp_tready) && rsp_tvalid && illegal
      |-> a_total == $past(a_total) && b_total == $past(b_total))
      else $error("edge totals moved on an illegal transition");

endmodule

bind quadrature_decoder_with_index qdi_checker u_qdi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

/* tb/sv/quadrature_decoder_with_index_tb.sv */
// Testbench for quadrature_decoder_with_index: directed and random pin samples,
// position loads and reload register writes, each result beat checked against a
// built-in model of the decoder. Depends on qdi_pkg and the decoder RTL.
module quadrature_decoder_with_index_tb;
   import qdi_pkg::*;

   localparam int unsigned TimeoutCycles = 400000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we;
   logic                    csr_index;
   logic [CountWidth-1:0]   csr_wdata;

   quadrature_decoder_with_index DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Decoder model state, mirrored from the block's behavior
   logic [CountWidth-1:0] reload_high;
   logic [CountWidth-1:0] reload_low;
   logic                  last_a;
   logic                  last_b;
   logic                  last_index;
   logic [CountWidth-1:0] pos;
   logic [CountWidth-1:0] pos_at_index;
   logic [CountWidth-1:0] edges_since;
   logic [CountWidth-1:0] edges_last_rev;
   logic [CountWidth-1:0] a_total;
   logic [CountWidth-1:0] b_total;
   logic [CountWidth-1:0] pulse_total;
   logic                  pulse_seen;

   // Decoder states still owed by the block, oldest first
   result_type pending_states[$];

   int unsigned fault_count;
   int unsigned send_idle_pct;
   int unsigned accept_idle_pct;

   // Run the clock: period 12
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bound the run; a hang ends here
   initial begin
      #(TimeoutCycles * 12);
      $display("TB_ERROR");
      $finish;
   end

   // Drive rsp_tready at each falling edge; stall at the current rate
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= accept_idle_pct);
      end
   end

   task automatic report_fault(string text);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", text);
   endtask

   task automatic check_field(string name, logic [CountWidth-1:0] got,
                              logic [CountWidth-1:0] want);
      if (got !== want)
         report_fault($sformatf("%s expected %h got %h", name, want, got));
   endtask

   // Advance the decoder model by one item and return the state it reports
   function automatic result_type decode_item(item_type it);
      result_type st;
      logic       a_moved;
      logic       b_moved;
      logic       up;
      st = '0;
      if (it.action == ACT_LOAD) begin
         // Load only takes effect when the value differs from the position
         if (pos != it.load_value) begin
            pos         = it.load_value;
            edges_since = it.load_value;
         end
      end else begin
         a_moved = (it.pin_a != last_a);
         b_moved = (it.pin_b != last_b);
         if (a_moved && b_moved) begin
            st.illegal_transition = 1'b1;
         end else if (a_moved) begin
            up          = it.pin_a ? !it.pin_b : it.pin_b;
            pos         = up ? pos + 1 : pos - 1;
            edges_since = edges_since + 1;
            a_total     = a_total + 1;
         end else if (b_moved) begin
            up          = it.pin_b ? it.pin_a : !it.pin_a;
            pos         = up ? pos + 1 : pos - 1;
            edges_since = edges_since + 1;
            b_total     = b_total + 1;
         end
         // Index rising edge: latch after the A/B edge, then reload
         if (it.pin_index && !last_index) begin
            pulse_seen     = 1'b1;
            pos_at_index   = pos;
            pos            = it.pin_dir ? reload_high : reload_low;
            edges_last_rev = edges_since;
            edges_since    = '0;
            pulse_total    = pulse_total + 1;
         end
         last_a     = it.pin_a;
         last_b     = it.pin_b;
         last_index = it.pin_index;
      end
      st.position              = pos;
      st.position_at_index     = pos_at_index;
      st.edges_since_index     = edges_since;
      st.edges_last_revolution = edges_last_rev;
      st.edges_on_a            = a_total;
      st.edges_on_b            = b_total;
      st.index_count           = pulse_total;
      st.index_seen            = pulse_seen;
      return st;
   endfunction

   // Present one beat from a falling edge, hold it until accepted, and
   // queue the state it must produce. Valid stays high for the next beat.
   task automatic send_item(item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.action;
      req_tdata  = {4'b0000, it.load_value, it.pin_dir, it.pin_index, it.pin_b, it.pin_a};
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_states.push_back(decode_item(it));
      @(negedge clock);
   endtask

   task automatic send_sample(logic a, logic b, logic ix, logic dir);
      item_type it;
      it            = '0;
      it.action     = ACT_SAMPLE;
      it.pin_a      = a;
      it.pin_b      = b;
      it.pin_index  = ix;
      it.pin_dir    = dir;
      it.load_value = $urandom;
      send_item(it);
   endtask

   task automatic send_load(logic [CountWidth-1:0] value);
      item_type it;
      it            = '0;
      it.action     = ACT_LOAD;
      // Pin fields are don't-care on a load; fill them with noise
      it.pin_a      = 1'($urandom_range(1));
      it.pin_b      = 1'($urandom_range(1));
      it.pin_index  = 1'($urandom_range(1));
      it.pin_dir    = 1'($urandom_range(1));
      it.load_value = value;
      send_item(it);
   endtask

   // Drain the block and wait while idle, then write one register
   task automatic write_reload(logic idx, logic [CountWidth-1:0] value);
      req_tvalid = 1'b0;
      while (pending_states.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_RELOAD_DIR_HIGH) reload_high = value;
      else reload_low = value;
   endtask

   // Forward and reverse through each rise and fall of A and B, wrap below zero,
   // and a double change on A and B
   task automatic test_quadrature_steps();
      send_sample(0, 0, 0, 0);
      send_sample(1, 0, 0, 0);
      send_sample(1, 1, 0, 0);
      send_sample(0, 1, 0, 0);
      send_sample(0, 0, 0, 0);
      send_sample(0, 1, 0, 1);
      send_sample(1, 1, 0, 1);
      send_sample(1, 0, 0, 1);
      send_sample(0, 0, 0, 1);
      send_sample(0, 1, 0, 0);
      send_sample(1, 0, 0, 0);
   endtask

   // Index rise with each direction, a held index, and an edge in the
   // same sample as the index
   task automatic test_index_pulses();
      send_sample(1, 0, 1, 0);
      send_sample(1, 0, 1, 1);
      send_sample(1, 0, 0, 1);
      send_sample(0, 0, 1, 1);
   endtask

   // Loads equal to and different from the position, extremes, and a
   // wrap above the top after a load
   task automatic test_position_loads();
      send_load(pos);
      send_load(32'hFFFF_FFFF);
      send_sample(1, 0, 0, 0);
      send_load(32'h8000_0000);
      send_load(32'h8000_0000);
   endtask

   // Extreme reload values, used by index pulses of both directions
   task automatic test_reload_registers();
      write_reload(CSR_RELOAD_DIR_HIGH, 32'hFFFF_FFFF);
      write_reload(CSR_RELOAD_DIR_LOW, 32'h0000_0000);
      send_sample(1, 0, 1, 1);
      send_sample(1, 1, 0, 0);
      send_sample(1, 1, 1, 0);
      send_sample(1, 1, 0, 0);
   endtask

   // Mostly legal encoder motion with runs in one direction, reversals,
   // pauses and index pulses; mixed with loads and random pin noise
   task automatic test_random_motion(int unsigned count);
      logic        moving_up;
      logic [1:0]  phase;
      int unsigned index_hold;
      int unsigned pick;
      logic        ix;
      moving_up  = 1'b1;
      index_hold = 0;
      repeat (count) begin
         pick = $urandom_range(99);
         if (index_hold > 0) begin
            ix = 1'b1;
            index_hold--;
         end else begin
            ix = 1'b0;
            if ($urandom_range(99) < 4) index_hold = $urandom_range(4, 1);
         end
         if (pick < 6) begin
            case ($urandom_range(3))
               0: send_load(pos);
               1: send_load($urandom);
               2: send_load(pos + $urandom_range(3) - 2);
               default:
                  case ($urandom_range(3))
                     0: send_load(32'h0000_0000);
                     1: send_load(32'hFFFF_FFFF);
                     2: send_load(32'h8000_0000);
                     default: send_load(32'h7FFF_FFFF);
                  endcase
            endcase
         end else if (pick < 14) begin
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            if ($urandom_range(99) < 8) moving_up = !moving_up;
            // Gray order 00, 10, 11, 01 counts up
            case ({last_a, last_b})
               2'b00:   phase = 2'd0;
               2'b10:   phase = 2'd1;
               2'b11:   phase = 2'd2;
               default: phase = 2'd3;
            endcase
            if ($urandom_range(99) >= 10) phase = moving_up ? phase + 2'd1 : phase - 2'd1;
            case (phase)
               2'd0:    send_sample(0, 0, ix, 1'($urandom_range(1)));
               2'd1:    send_sample(1, 0, ix, 1'($urandom_range(1)));
               2'd2:    send_sample(1, 1, ix, 1'($urandom_range(1)));
               default: send_sample(0, 1, ix, 1'($urandom_range(1)));
            endcase
         end
      end
   endtask

   // Check each accepted result beat against the oldest queued state
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_states.size() == 0) begin
            report_fault($sformatf("result beat with nothing pending: %h", rsp_tdata));
         end else begin
            want = pending_states.pop_front();
            got  = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            check_field("position", got.position, want.position);
            check_field("position_at_index", got.position_at_index,
                        want.position_at_index);
            check_field("edges_since_index", got.edges_since_index,
                        want.edges_since_index);
            check_field("edges_last_revolution", got.edges_last_revolution,
                        want.edges_last_revolution);
            check_field("edges_on_a", got.edges_on_a, want.edges_on_a);
            check_field("edges_on_b", got.edges_on_b, want.edges_on_b);
            check_field("index_count", got.index_count, want.index_count);
            check_field("index_seen", {31'd0, got.index_seen},
                        {31'd0, want.index_seen});
            check_field("illegal_transition", {31'd0, got.illegal_transition},
                        {31'd0, want.illegal_transition});
         end
      end
   end

   initial begin
      // Hold reset with every input at a known value
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = ACT_SAMPLE;
      csr_we      = 1'b0;
      csr_index   = CSR_RELOAD_DIR_HIGH;
      csr_wdata   = '0;
      fault_count = 0;
      send_idle_pct   = 31;
      accept_idle_pct = 80;

      reload_high    = RELOAD_DIR_HIGH_RESET;
      reload_low     = RELOAD_DIR_LOW_RESET;
      last_a         = 1'b0;
      last_b         = 1'b0;
      last_index     = 1'b0;
      pos            = '0;
      pos_at_index   = '0;
      edges_since    = '0;
      edges_last_rev = '0;
      a_total        = '0;
      b_total        = '0;
      pulse_total    = '0;
      pulse_seen     = 1'b0;

      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed beats run with a slow receiver
      test_quadrature_steps();
      test_index_pulses();
      test_position_loads();
      test_reload_registers();
      test_random_motion(550);

      // Swap the idle rates and move to random reload values
      write_reload(CSR_RELOAD_DIR_HIGH, $urandom);
      write_reload(CSR_RELOAD_DIR_LOW, $urandom);
      send_idle_pct   = 80;
      accept_idle_pct = 31;
      test_random_motion(550);

      // Full rate, reload values at the opposite extremes
      write_reload(CSR_RELOAD_DIR_HIGH, 32'h0000_0000);
      write_reload(CSR_RELOAD_DIR_LOW, 32'hFFFF_FFFF);
      send_idle_pct   = 0;
      accept_idle_pct = 0;
      test_random_motion(550);

      // Drop valid, drain the pending states, then watch for stray beats
      req_tvalid = 1'b0;
      while (pending_states.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/qdi_pkg.sv
sv/qdi_in_stage.sv
sv/qdi_core.sv
sv/qdi_out_stage.sv
sv/quadrature_decoder_with_index.sv
sv/qdi_checker.sv
tb/sv/quadrature_decoder_with_index_tb.sv
